FILE: hw/rtl/skt_pkg.sv
package skt_pkg;

  // Default sizes and fixed port widths
  localparam int unsigned CAPACITY_DEF     = 64;
  localparam int unsigned PAYLOAD_BITS_DEF = 16;
  localparam int unsigned KEY_BITS         = 32;
  localparam int unsigned PAY_PORT_BITS    = 16;
  localparam int unsigned COUNT_PORT_BITS  = 7;

  // Command codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // Command word
  typedef struct packed {
    logic [1:0]                 op;
    logic signed [KEY_BITS-1:0] key;
    logic [PAY_PORT_BITS-1:0]   payload;
  } skt_cmd_t;

  // Result word
  typedef struct packed {
    logic [1:0]                 status;
    logic                       found;
    logic [PAY_PORT_BITS-1:0]   found_payload;
    logic [COUNT_PORT_BITS-1:0] entry_count;
  } skt_res_t;

  // Index register update
  typedef enum logic [2:0] {
    IDX_HOLD  = 3'd0,
    IDX_COUNT = 3'd1,
    IDX_ZERO  = 3'd2,
    IDX_INC   = 3'd3,
    IDX_DEC   = 3'd4
  } idx_op_e;

  // Read address relative to the next index
  typedef enum logic [1:0] {
    OFF_ZERO = 2'd0,
    OFF_DOWN = 2'd1,
    OFF_UP   = 2'd2
  } rd_off_e;

  // Write data source
  typedef enum logic {
    WR_NEW  = 1'b0,
    WR_MOVE = 1'b1
  } wr_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic    latch_in;
    idx_op_e idx_op;
    rd_off_e rd_off;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_ld;
    status_e res_status;
    logic    res_found;
  } skt_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] in_op;
    logic [1:0] op_q;
    logic       count_zero;
    logic       count_full;
    logic       ins_move;
    logic       key_match;
    logic       idx_one;
    logic       last_srch;
    logic       last_del;
  } skt_sts_t;

endpackage

FILE: hw/rtl/skt_ctrl.sv
module skt_ctrl
  import skt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output logic     result_valid_o,
  input  skt_sts_t sts_i,
  output skt_ctl_t ctl_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_INS  = 6'b000010,
    S_PUT  = 6'b000100,
    S_SRCH = 6'b001000,
    S_DEL  = 6'b010000,
    S_RESP = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Sequence the table operations
  always_comb begin
    state_d           = state_q;
    ctl_o             = '0;
    ctl_o.idx_op      = IDX_HOLD;
    ctl_o.rd_off      = OFF_ZERO;
    ctl_o.wr_sel      = WR_NEW;
    ctl_o.res_status  = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.latch_in = 1'b1;
          unique case (sts_i.in_op)
            OP_INSERT: begin
              ctl_o.idx_op = IDX_COUNT;
              if (sts_i.count_full) begin
                ctl_o.res_ld     = 1'b1;
                ctl_o.res_status = ST_FULL;
                state_d          = S_RESP;
              end else if (sts_i.count_zero) begin
                state_d = S_PUT;
              end else begin
                state_d = S_INS;
              end
            end
            OP_LOOKUP, OP_REMOVE: begin
              ctl_o.idx_op = IDX_ZERO;
              if (sts_i.count_zero) begin
                ctl_o.res_ld     = 1'b1;
                ctl_o.res_status = ST_NOT_FOUND;
                state_d          = S_RESP;
              end else begin
                state_d = S_SRCH;
              end
            end
            default: begin
              ctl_o.res_ld = 1'b1;
              state_d      = S_RESP;
            end
          endcase
        end
      end
      S_INS: begin
        ctl_o.wr_en = 1'b1;
        if (sts_i.ins_move) begin
          ctl_o.wr_sel = WR_MOVE;
          ctl_o.idx_op = IDX_DEC;
          if (sts_i.idx_one) begin
            state_d = S_PUT;
          end
        end else begin
          ctl_o.cnt_inc = 1'b1;
          ctl_o.res_ld  = 1'b1;
          state_d       = S_RESP;
        end
      end
      S_PUT: begin
        ctl_o.wr_en   = 1'b1;
        ctl_o.cnt_inc = 1'b1;
        ctl_o.res_ld  = 1'b1;
        state_d       = S_RESP;
      end
      S_SRCH: begin
        if (sts_i.key_match) begin
          ctl_o.res_ld    = 1'b1;
          ctl_o.res_found = 1'b1;
          if (sts_i.op_q == OP_REMOVE && !sts_i.last_srch) begin
            state_d = S_DEL;
          end else begin
            ctl_o.cnt_dec = (sts_i.op_q == OP_REMOVE);
            state_d       = S_RESP;
          end
        end else if (sts_i.last_srch) begin
          ctl_o.res_ld     = 1'b1;
          ctl_o.res_status = ST_NOT_FOUND;
          state_d          = S_RESP;
        end else begin
          ctl_o.idx_op = IDX_INC;
        end
      end
      S_DEL: begin
        ctl_o.wr_en  = 1'b1;
        ctl_o.wr_sel = WR_MOVE;
        ctl_o.idx_op = IDX_INC;
        if (sts_i.last_del) begin
          ctl_o.cnt_dec = 1'b1;
          state_d       = S_RESP;
        end
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Point the read port at the neighbour the next state compares
    unique case (state_d)
      S_INS:   ctl_o.rd_off = OFF_DOWN;
      S_DEL:   ctl_o.rd_off = OFF_UP;
      default: ctl_o.rd_off = OFF_ZERO;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_RESP);

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_strobe_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy && !result_valid_o)
    else $error("block not free after result strobe");

  a_one_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_o.cnt_inc && ctl_o.cnt_dec))
    else $error("count raised and lowered together");

  a_result_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.cnt_inc || ctl_o.cnt_dec) |=> result_valid_o)
    else $error("count change not followed by result");
`endif

endmodule

FILE: hw/rtl/skt_datapath.sv
module skt_datapath
  import skt_pkg::*;
#(
  parameter int unsigned CAPACITY     = CAPACITY_DEF,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  skt_cmd_t cmd_i,
  input  skt_ctl_t ctl_i,
  output skt_sts_t sts_o,
  output skt_res_t result_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SB = (PAYLOAD_BITS < PAY_PORT_BITS) ? PAYLOAD_BITS : PAY_PORT_BITS;

  // Table storage
  logic signed [KEY_BITS-1:0] key_mem [CAPACITY];
  logic [SB-1:0]              pay_mem [CAPACITY];

  logic [1:0]                 op_q;
  logic signed [KEY_BITS-1:0] key_q;
  logic [SB-1:0]              pay_q;
  logic [CW-1:0]              idx_q, idx_d;
  logic [CW-1:0]              count_q;
  logic [CW-1:0]              rd_idx;
  logic signed [KEY_BITS-1:0] rd_key_q;
  logic [SB-1:0]              rd_pay_q;
  logic signed [KEY_BITS-1:0] wr_key;
  logic [SB-1:0]              wr_pay;
  logic [CW:0]                idx_p1, idx_p2;
  logic [1:0]                 status_q;
  logic                       found_q;
  logic [SB-1:0]              fpay_q;
  logic [PAY_PORT_BITS+SB-1:0]     fpay_ext;
  logic [COUNT_PORT_BITS+CW-1:0]   count_ext;

  // Latch the command word
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch_in) begin
      key_q <= cmd_i.key;
      pay_q <= cmd_i.payload[SB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_INSERT;
    end else if (ctl_i.latch_in) begin
      op_q <= cmd_i.op;
    end
  end

  // Step the working index
  always_comb begin
    case (ctl_i.idx_op)
      IDX_COUNT: idx_d = count_q;
      IDX_ZERO:  idx_d = '0;
      IDX_INC:   idx_d = idx_q + CW'(1);
      IDX_DEC:   idx_d = idx_q - CW'(1);
      default:   idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // Hold the entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctl_i.cnt_inc) begin
      count_q <= count_q + CW'(1);
    end else if (ctl_i.cnt_dec) begin
      count_q <= count_q - CW'(1);
    end
  end

  // Read the neighbour that the next step needs
  always_comb begin
    case (ctl_i.rd_off)
      OFF_DOWN: rd_idx = idx_d - CW'(1);
      OFF_UP:   rd_idx = idx_d + CW'(1);
      default:  rd_idx = idx_d;
    endcase
  end

  assign wr_key = (ctl_i.wr_sel == WR_MOVE) ? rd_key_q : key_q;
  assign wr_pay = (ctl_i.wr_sel == WR_MOVE) ? rd_pay_q : pay_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      key_mem[idx_q[AW-1:0]] <= wr_key;
      pay_mem[idx_q[AW-1:0]] <= wr_pay;
    end
    rd_key_q <= key_mem[rd_idx[AW-1:0]];
    rd_pay_q <= pay_mem[rd_idx[AW-1:0]];
  end

  // Compare and report
  assign idx_p1 = {1'b0, idx_q} + (CW+1)'(1);
  assign idx_p2 = {1'b0, idx_q} + (CW+1)'(2);

  always_comb begin
    sts_o.in_op      = cmd_i.op;
    sts_o.op_q       = op_q;
    sts_o.count_zero = (count_q == '0);
    sts_o.count_full = (count_q == CW'(CAPACITY));
    sts_o.idx_one    = (idx_q == CW'(1));
    sts_o.ins_move   = sts_o.idx_one ? (key_q < rd_key_q) : (rd_key_q >= key_q);
    sts_o.key_match  = (rd_key_q == key_q);
    sts_o.last_srch  = (idx_p1 >= {1'b0, count_q});
    sts_o.last_del   = (idx_p2 >= {1'b0, count_q});
  end

  // Capture the result word
  always_ff @(posedge clk_i) begin
    if (ctl_i.res_ld) begin
      status_q <= ctl_i.res_status;
      found_q  <= ctl_i.res_found;
      fpay_q   <= ctl_i.res_found ? rd_pay_q : '0;
    end
  end

  assign fpay_ext  = {PAY_PORT_BITS'(0), fpay_q};
  assign count_ext = {COUNT_PORT_BITS'(0), count_q};

  always_comb begin
    result_o.status        = status_q;
    result_o.found         = found_q;
    result_o.found_payload = fpay_ext[PAY_PORT_BITS-1:0];
    result_o.entry_count   = count_ext[COUNT_PORT_BITS-1:0];
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_write_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.wr_en |-> idx_q < CW'(CAPACITY))
    else $error("table write beyond capacity");

  a_no_insert_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.cnt_inc |-> count_q < CW'(CAPACITY))
    else $error("insert into full table");

  a_no_remove_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.cnt_dec |-> count_q != '0)
    else $error("remove from empty table");
`endif

endmodule

FILE: hw/rtl/sorted_key_table_top.sv
// From accepted command to result strobe: an insert shifts the entries above its
// position up one at a time, then writes the new entry; a lookup or remove scans
// from index zero to a match or the last entry, and a remove then shifts the rest
// down; an insert into a full table, a lookup or remove on an empty one, or an
// unused code goes straight to the result. Throughput: one command at a time; the
// scan or shift moves one entry per cycle; start is taken the cycle after strobe.
module sorted_key_table_top
  import skt_pkg::*;
#(
  parameter int unsigned CAPACITY     = CAPACITY_DEF,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  skt_cmd_t cmd_i,
  output logic     result_valid_o,
  output skt_res_t result_o
);

  skt_ctl_t ctl;
  skt_sts_t sts;

  skt_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .sts_i          (sts),
    .ctl_o          (ctl)
  );

  skt_datapath #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .ctl_i    (ctl),
    .sts_o    (sts),
    .result_o (result_o)
  );

endmodule

FILE: tb/tb_sorted_key_table_top.sv
module tb_sorted_key_table_top;
  import skt_pkg::*;

  localparam int unsigned TABLE_DEPTH   = CAPACITY_DEF;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam int unsigned RANDOM_WORDS  = 1300;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef enum int {
    PH_GROW,
    PH_SHRINK,
    PH_MIXED
  } phase_e;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  skt_cmd_t cmd_i;
  logic     result_valid_o;
  skt_res_t result_o;

  // Shadow copy of the table contents
  logic signed [KEY_BITS-1:0]      tbl_key [TABLE_DEPTH];
  logic        [PAY_PORT_BITS-1:0] tbl_pay [TABLE_DEPTH];
  int unsigned                     tbl_len;

  skt_res_t    pending_results [$];
  int unsigned mismatch_count;
  int unsigned no_idle_left;
  int unsigned stall_cycles;

  sorted_key_table_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // Clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Apply one command word to the shadow table and return the expected result
  function automatic skt_res_t table_apply(skt_cmd_t c);
    skt_res_t                   r;
    logic signed [KEY_BITS-1:0] k;
    int unsigned                pos;
    int unsigned                i;
    bit                         hit;
    r   = '0;
    k   = c.key;
    hit = 1'b0;
    pos = 0;
    if (c.op == OP_INSERT) begin
      if (tbl_len >= TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // an equal key never goes in front of the head entry
        if (tbl_len == 0 || k < tbl_key[0]) begin
          pos = 0;
        end else begin
          pos = 1;
          while (pos < tbl_len && tbl_key[pos] < k) pos++;
        end
        for (i = tbl_len; i > pos; i--) begin
          tbl_key[i] = tbl_key[i-1];
          tbl_pay[i] = tbl_pay[i-1];
        end
        tbl_key[pos] = k;
        tbl_pay[pos] = c.payload;
        tbl_len++;
        r.status = ST_OK;
      end
    end else if (c.op == OP_LOOKUP || c.op == OP_REMOVE) begin
      // first entry with a matching key
      for (i = 0; i < tbl_len && !hit; i++) begin
        if (tbl_key[i] == k) begin
          hit = 1'b1;
          pos = i;
        end
      end
      if (!hit) begin
        r.status = ST_NOT_FOUND;
      end else begin
        r.status        = ST_OK;
        r.found         = 1'b1;
        r.found_payload = tbl_pay[pos];
        if (c.op == OP_REMOVE) begin
          for (i = pos; i + 1 < tbl_len; i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_pay[i] = tbl_pay[i+1];
          end
          tbl_len--;
        end
      end
    end else begin
      r.status = ST_OK;
    end
    r.entry_count = tbl_len[COUNT_PORT_BITS-1:0];
    return r;
  endfunction

  // Draw a key: mostly present or from a narrow pool, sometimes extreme or wide
  function automatic logic signed [KEY_BITS-1:0] pick_key();
    int unsigned sel;
    int          v;
    sel = $urandom_range(0, 9);
    v   = $urandom_range(0, 16);
    if (tbl_len != 0 && sel < 4) return tbl_key[$urandom_range(0, tbl_len - 1)];
    if (sel < 8) return v - 8;
    if (sel == 8) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return $urandom;
  endfunction

  // Draw a payload handle
  function automatic logic [PAY_PORT_BITS-1:0] pick_payload();
    return PAY_PORT_BITS'($urandom_range(0, 65535));
  endfunction

  // Send one command word, with a random hold-off before it
  task automatic send_cmd(input logic [1:0] op, input logic signed [KEY_BITS-1:0] key,
                          input logic [PAY_PORT_BITS-1:0] payload);
    skt_cmd_t    c;
    int unsigned gap;
    c.op      = op;
    c.key     = key;
    c.payload = payload;
    if (no_idle_left > 0) begin
      no_idle_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 19) == 0) no_idle_left = $urandom_range(10, 40);
      gap = $urandom_range(0, 8);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    // hold until the block takes the word
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_results.push_back(table_apply(c));
  endtask

  // Hold the sender until every expected result has arrived
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_table();
    send_cmd(OP_LOOKUP, 0, 16'h0000);
    send_cmd(OP_REMOVE, -1, 16'hFFFF);
    send_cmd(OP_UNUSED, 32'sh7FFF_FFFF, 16'hFFFF);
    drain_results();
  endtask

  task automatic test_key_extremes();
    send_cmd(OP_INSERT, 32'sh7FFF_FFFF, 16'hFFFF);
    send_cmd(OP_INSERT, 32'sh8000_0000, 16'h0000);
    send_cmd(OP_INSERT, 0, 16'hA5A5);
    send_cmd(OP_INSERT, -1, 16'h5A5A);
    send_cmd(OP_LOOKUP, 32'sh8000_0000, 16'hFFFF);
    send_cmd(OP_LOOKUP, 32'sh7FFF_FFFF, 16'h0000);
    send_cmd(OP_REMOVE, 32'sh7FFF_FFFF, 16'h0000);
    send_cmd(OP_REMOVE, 32'sh8000_0000, 16'h0000);
    send_cmd(OP_REMOVE, 0, 16'h0000);
    send_cmd(OP_REMOVE, -1, 16'h0000);
    drain_results();
  endtask

  // Equal keys: one equal to the head goes after it, later ones go before
  task automatic test_duplicate_keys();
    send_cmd(OP_INSERT, 5, 16'h0001);
    send_cmd(OP_INSERT, 5, 16'h0002);
    send_cmd(OP_INSERT, 3, 16'h0003);
    send_cmd(OP_INSERT, 3, 16'h0004);
    send_cmd(OP_INSERT, 5, 16'h0005);
    send_cmd(OP_LOOKUP, 5, 16'h0000);
    send_cmd(OP_REMOVE, 5, 16'h0000);
    send_cmd(OP_LOOKUP, 3, 16'h0000);
    send_cmd(OP_REMOVE, 3, 16'h0000);
    send_cmd(OP_UNUSED, 3, 16'h0000);
    send_cmd(OP_LOOKUP, 4, 16'h0000);
    drain_results();
  endtask

  // Fill the table, then try to insert at both ends
  task automatic test_full_table();
    while (tbl_len < TABLE_DEPTH) send_cmd(OP_INSERT, pick_key(), pick_payload());
    send_cmd(OP_INSERT, 32'sh8000_0000, 16'hFFFF);
    send_cmd(OP_INSERT, 32'sh7FFF_FFFF, 16'h0000);
    send_cmd(OP_UNUSED, 0, 16'h1234);
    send_cmd(OP_LOOKUP, tbl_key[TABLE_DEPTH-1], 16'h0000);
    send_cmd(OP_REMOVE, tbl_key[0], 16'h0000);
    send_cmd(OP_INSERT, pick_key(), pick_payload());
    send_cmd(OP_INSERT, pick_key(), pick_payload());
    drain_results();
  endtask

  // Random traffic in phases that grow, shrink or churn the table
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned phase_len;
    int unsigned r;
    int unsigned t_ins;
    int unsigned t_look;
    phase_e      ph;
    logic [1:0]  op;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      ph        = phase_e'($urandom_range(0, 2));
      phase_len = $urandom_range(40, 150);
      case (ph)
        PH_GROW: begin
          t_ins  = 60;
          t_look = 80;
        end
        PH_SHRINK: begin
          t_ins  = 20;
          t_look = 40;
        end
        default: begin
          t_ins  = 40;
          t_look = 65;
        end
      endcase
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        if (r < t_ins) op = OP_INSERT;
        else if (r < t_look) op = OP_LOOKUP;
        else if (r < 96) op = OP_REMOVE;
        else op = OP_UNUSED;
        send_cmd(op, pick_key(), pick_payload());
        sent++;
      end
      if ($urandom_range(0, 9) < 3) drain_results();
    end
    drain_results();
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    skt_res_t want;
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT)
          $display("unexpected result: status %0d found %0d payload %h count %0d",
                   result_o.status, result_o.found, result_o.found_payload,
                   result_o.entry_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_o.status !== want.status || result_o.found !== want.found ||
            result_o.found_payload !== want.found_payload ||
            result_o.entry_count !== want.entry_count) begin
          if (mismatch_count < REPORT_LIMIT)
            $display({"mismatch: expected status %0d found %0d payload %h count %0d,",
                      " got status %0d found %0d payload %h count %0d"},
                     want.status, want.found, want.found_payload, want.entry_count,
                     result_o.status, result_o.found, result_o.found_payload,
                     result_o.entry_count);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no word moving in either direction
  always @(posedge clk_i) begin
    if ((rst_ni === 1'b1 && start === 1'b1 && busy === 1'b0) || result_valid_o === 1'b1)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    cmd_i          = '0;
    tbl_len        = 0;
    mismatch_count = 0;
    no_idle_left   = 0;
    stall_cycles   = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_key_extremes();
    test_duplicate_keys();
    test_full_table();
    test_random_traffic();

    // let the block settle before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
